// ===== rtl/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants for the signed distance field engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

	// Default bitmap limits
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SPREAD = 2'd2;

	// Register reset values
	localparam logic [10:0] RST_WIDTH  = 11'd1024;
	localparam logic [10:0] RST_HEIGHT = 11'd1024;
	localparam logic [7:0]  RST_SPREAD = 8'd64;
	localparam logic [7:0]  MIN_SPREAD = 8'd16;

	// Item actions
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Square root and divider step counts
	localparam int ROOT_STEPS = 13;
	localparam int DIV_STEPS  = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE_RD,
		ST_BASE_CAP,
		ST_SCAN,
		ST_DRAIN,
		ST_ROOT,
		ST_CLAMP,
		ST_DIVIDE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic take;
		logic base_rd;
		logic base_cap;
		logic scan;
		logic root;
		logic clamp;
		logic divide;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic bad;
		logic scan_last;
		logic root_last;
		logic div_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/sdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdf_ctrl
// Sequencer for loads and queries: base read, window scan, root, divide.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           action,
	input  sdf_pkg::sts_t       sts,
	output sdf_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                done
);

	sdf_pkg::state_t state_q, state_d;
	logic            done_q, done_d;
	logic            take;

	assign take = start && !busy;
	assign busy = (state_q != sdf_pkg::ST_IDLE) || done_q;
	assign done = done_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdf_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			sdf_pkg::ST_IDLE: begin
				if (take && action == sdf_pkg::ACT_QUERY) begin
					if (sts.bad) done_d = 1'b1;
					else state_d = sdf_pkg::ST_BASE_RD;
				end
			end
			sdf_pkg::ST_BASE_RD:  state_d = sdf_pkg::ST_BASE_CAP;
			sdf_pkg::ST_BASE_CAP: state_d = sdf_pkg::ST_SCAN;
			sdf_pkg::ST_SCAN: begin
				if (sts.scan_last) state_d = sdf_pkg::ST_DRAIN;
			end
			sdf_pkg::ST_DRAIN: state_d = sdf_pkg::ST_ROOT;
			sdf_pkg::ST_ROOT: begin
				if (sts.root_last) state_d = sdf_pkg::ST_CLAMP;
			end
			sdf_pkg::ST_CLAMP: state_d = sdf_pkg::ST_DIVIDE;
			sdf_pkg::ST_DIVIDE: begin
				if (sts.div_last) begin
					state_d = sdf_pkg::ST_IDLE;
					done_d  = 1'b1;
				end
			end
			default: state_d = sdf_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.take     = take;
		cmd.base_rd  = (state_q == sdf_pkg::ST_BASE_RD);
		cmd.base_cap = (state_q == sdf_pkg::ST_BASE_CAP);
		cmd.scan     = (state_q == sdf_pkg::ST_SCAN);
		cmd.root     = (state_q == sdf_pkg::ST_ROOT);
		cmd.clamp    = (state_q == sdf_pkg::ST_CLAMP);
		cmd.divide   = (state_q == sdf_pkg::ST_DIVIDE);
	end

	// A result strobe lasts one cycle
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held");

	// A load never leaves the idle state
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(take && action == sdf_pkg::ACT_LOAD) |=> state_q == sdf_pkg::ST_IDLE)
		else $error("load started a sequence");

	// The scan keeps going until the last window pixel
	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sdf_pkg::ST_SCAN && !sts.scan_last) |=> state_q == sdf_pkg::ST_SCAN)
		else $error("scan left early");

endmodule

`default_nettype wire

// ===== rtl/sdf_datapath.sv =====
// ----------------------------------------------------------------------------
// sdf_datapath
// Bitmap store, registers, window scan, square root and alpha divider.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_datapath #(
	parameter int MAX_WIDTH  = sdf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sdf_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  sdf_pkg::cmd_t    cmd,
	output sdf_pkg::sts_t    sts,
	input  wire logic        action,
	input  wire logic [9:0]  x,
	input  wire logic [9:0]  y,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic [7:0]  alpha_in,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	output logic [7:0]       alpha_out,
	output logic signed [13:0] signed_distance,
	output logic             is_inside,
	output logic             bad_coordinate
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	// Bitmap store
	logic mem [DEPTH];
	logic rd_q;
	logic [AW-1:0] wr_addr, rd_addr;

	// Registers
	logic [10:0] width_q, height_q;
	logic [7:0]  spread_q;
	logic [10:0] w_eff, h_eff;
	logic [7:0]  sp_eff;
	logic [4:0]  delta;
	logic [11:0] lim;

	// Query state
	logic [10:0] xq_q, yq_q, x0_q, x1_q, y1_q, cx_q, cy_q;
	logic [10:0] x0_d, x1_d, y0_d, y1_d, xp, yp;
	logic        base_q, bad_q, cmp_s1;
	logic [4:0]  dx_s1, dy_s1;
	logic [8:0]  best_q;
	logic [9:0]  sq;

	// Root and divider state
	logic [25:0] rv_q, rres_q, rv, rres, rbit, rsum;
	logic [3:0]  rcnt_q;
	logic [12:0] dist_c;
	logic signed [13:0] sd_q, sd_d;
	logic [20:0] rem_q, dsh;
	logic [12:0] den_q;
	logic [2:0]  dcnt_q;
	logic [7:0]  quot_q;
	logic [12:0] sum_c;

	// Effective configuration
	always_comb begin
		if (width_q == 11'd0) w_eff = 11'd1;
		else if ({2'b0, width_q} > 13'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
		else w_eff = width_q;
		if (height_q == 11'd0) h_eff = 11'd1;
		else if ({2'b0, height_q} > 13'(MAX_HEIGHT)) h_eff = 11'(MAX_HEIGHT);
		else h_eff = height_q;
		sp_eff = (spread_q < sdf_pkg::MIN_SPREAD) ? sdf_pkg::MIN_SPREAD : spread_q;
		delta  = 5'(({1'b0, sp_eff} + 9'd15) >> 4);
		lim    = {sp_eff, 4'b0};
	end

	assign xp = {1'b0, x};
	assign yp = {1'b0, y};
	assign sts.bad = !(xp < w_eff && yp < h_eff);

	// Window corners from the item ports
	always_comb begin
		x0_d = (xp > 11'(delta)) ? xp - 11'(delta) : 11'd0;
		y0_d = (yp > 11'(delta)) ? yp - 11'(delta) : 11'd0;
		x1_d = (xp + 11'(delta) < w_eff - 11'd1) ? xp + 11'(delta) : w_eff - 11'd1;
		y1_d = (yp + 11'(delta) < h_eff - 11'd1) ? yp + 11'(delta) : h_eff - 11'd1;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sdf_pkg::RST_WIDTH;
			height_q <= sdf_pkg::RST_HEIGHT;
			spread_q <= sdf_pkg::RST_SPREAD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdf_pkg::REG_WIDTH:  width_q  <= cfg_data;
				sdf_pkg::REG_HEIGHT: height_q <= cfg_data;
				sdf_pkg::REG_SPREAD: spread_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Store access
	assign wr_addr = AW'(32'(y) * 32'(MAX_WIDTH) + 32'(x));
	assign rd_addr = cmd.base_rd ? AW'(32'(yq_q) * 32'(MAX_WIDTH) + 32'(xq_q))
	                             : AW'(32'(cy_q) * 32'(MAX_WIDTH) + 32'(cx_q));

	always_ff @(posedge clk) begin
		if (cmd.take && action == sdf_pkg::ACT_LOAD && !sts.bad)
			mem[wr_addr] <= (red[7] | green[7] | blue[7]) & alpha_in[7];
		rd_q <= mem[rd_addr];
	end

	// Window scan
	assign sts.scan_last = (cx_q == x1_q) && (cy_q == y1_q);
	assign sq = 10'(dx_s1 * dx_s1) + 10'(dy_s1 * dy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_s1 <= 1'b0;
		end else begin
			cmp_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			xq_q   <= xp;
			yq_q   <= yp;
			x0_q   <= x0_d;
			x1_q   <= x1_d;
			y1_q   <= y1_d;
			cx_q   <= x0_d;
			cy_q   <= y0_d;
			best_q <= 9'(delta * delta);
			bad_q  <= sts.bad;
		end
		if (cmd.base_cap) base_q <= rd_q;
		if (cmd.scan) begin
			dx_s1 <= 5'((cx_q > xq_q) ? cx_q - xq_q : xq_q - cx_q);
			dy_s1 <= 5'((cy_q > yq_q) ? cy_q - yq_q : yq_q - cy_q);
			if (cx_q == x1_q) begin
				cx_q <= x0_q;
				cy_q <= cy_q + 11'd1;
			end else begin
				cx_q <= cx_q + 11'd1;
			end
		end
		// Compare the pixel read in the cycle before
		if (cmp_s1 && rd_q != base_q && sq < {1'b0, best_q})
			best_q <= sq[8:0];
	end

	// Square root, one result bit per step
	assign rv   = (rcnt_q == 4'd0) ? {1'b0, best_q, 16'b0} : rv_q;
	assign rres = (rcnt_q == 4'd0) ? 26'd0 : rres_q;
	assign rbit = 26'd1 << (5'd24 - {rcnt_q, 1'b0});
	assign rsum = rres + rbit;
	assign sts.root_last = (rcnt_q == 4'(sdf_pkg::ROOT_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
		end else if (cmd.root) begin
			rcnt_q <= sts.root_last ? 4'd0 : rcnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.root) begin
			if (rv >= rsum) begin
				rv_q   <= rv - rsum;
				rres_q <= (rres >> 1) + rbit;
			end else begin
				rv_q   <= rv;
				rres_q <= rres >> 1;
			end
		end
	end

	// Clamp, sign and numerator
	always_comb begin
		dist_c = (rres_q[12:0] > {1'b0, lim}) ? {1'b0, lim} : rres_q[12:0];
		sd_d   = base_q ? $signed({1'b0, dist_c}) : -$signed({1'b0, dist_c});
		sum_c  = 13'($signed({2'b0, lim}) + sd_d);
	end

	// Alpha divider, one quotient bit per step
	assign dsh = 21'(den_q) << (3'd7 - dcnt_q);
	assign sts.div_last = (dcnt_q == 3'(sdf_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.divide) begin
			dcnt_q <= dcnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			sd_q  <= sd_d;
			rem_q <= ({8'b0, sum_c} << 8) - {8'b0, sum_c};
			den_q <= {lim, 1'b0};
		end
		if (cmd.divide) begin
			if (rem_q >= dsh) begin
				rem_q  <= rem_q - dsh;
				quot_q <= {quot_q[6:0], 1'b1};
			end else begin
				quot_q <= {quot_q[6:0], 1'b0};
			end
		end
	end

	// Result fields
	assign alpha_out       = bad_q ? 8'd0 : quot_q;
	assign signed_distance = bad_q ? 14'sd0 : sd_q;
	assign is_inside       = bad_q ? 1'b0 : base_q;
	assign bad_coordinate  = bad_q;

endmodule

`default_nettype wire

// ===== rtl/signed_distance_field.sv =====
// ----------------------------------------------------------------------------
// signed_distance_field
// Brute-force signed distance field over a one-bit inside bitmap.
// ----------------------------------------------------------------------------
//  channel   signals                                     handshake
//  item      start, action, x, y, red, green, blue,     start & !busy
//            alpha_in
//  result    alpha_out, signed_distance, is_inside,      done, one cycle
//            bad_coordinate
//  config    cfg_index, cfg_data                         cfg_valid & cfg_ready
//
// A load is accepted while idle; busy stays low. After its accepting edge a query
// inside the image holds busy through the base read and capture, the window scan
// ((x1-x0+1)*(y1-y0+1) pixels, one bitmap read port, up to 33 x 33), the compare
// drain, 13 square root steps, the clamp, 8 divider steps and the result cycle.
// A query outside the image gives its result in the cycle after it is taken.
// Reset clears control state and restores the registers; the bitmap holds
// nothing until written. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_distance_field #(
	parameter int MAX_WIDTH  = sdf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sdf_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [9:0]  x,
	input  wire logic [9:0]  y,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic [7:0]  alpha_in,
	output logic             done,
	output logic [7:0]       alpha_out,
	output logic signed [13:0] signed_distance,
	output logic             is_inside,
	output logic             bad_coordinate,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);

	sdf_pkg::cmd_t cmd;
	sdf_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	sdf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	sdf_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.action          (action),
		.x               (x),
		.y               (y),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.alpha_in        (alpha_in),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.alpha_out       (alpha_out),
		.signed_distance (signed_distance),
		.is_inside       (is_inside),
		.bad_coordinate  (bad_coordinate)
	);

endmodule

`default_nettype wire

// ===== tb/signed_distance_field_tb.sv =====
// ----------------------------------------------------------------------------
// signed_distance_field_tb
// Self-checking bench for the signed distance field engine. Each phase sets
// the image size and spread, fills a region of the bitmap around the pixels
// it will query, then mixes queries, rewrites, ignored loads and queries
// outside the image. A behavioural copy of the engine predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_distance_field_tb;

	localparam int MAP_W      = 1024;
	localparam int MAP_H      = 1024;
	localparam int STALL_LIMIT = 20000;
	// register index with no register behind it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0]         alpha;
		logic signed [13:0] sdist;
		logic               is_in;
		logic               bad;
	} sdf_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	logic        action    = sdf_pkg::ACT_LOAD;
	logic [9:0]  px        = '0;
	logic [9:0]  py        = '0;
	logic [7:0]  red       = '0;
	logic [7:0]  green     = '0;
	logic [7:0]  blue      = '0;
	logic [7:0]  alpha_in  = '0;
	logic        done;
	logic [7:0]  alpha_out;
	logic signed [13:0] signed_distance;
	logic        is_inside;
	logic        bad_coordinate;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = sdf_pkg::REG_WIDTH;
	logic [10:0] cfg_data  = '0;

	signed_distance_field u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .x(px), .y(py), .red(red), .green(green),
		.blue(blue), .alpha_in(alpha_in), .done(done), .alpha_out(alpha_out),
		.signed_distance(signed_distance), .is_inside(is_inside),
		.bad_coordinate(bad_coordinate), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state: bitmap and register copies
	bit          pixel_map [0:MAP_W*MAP_H-1];
	logic [10:0] img_w  = sdf_pkg::RST_WIDTH;
	logic [10:0] img_h  = sdf_pkg::RST_HEIGHT;
	logic [7:0]  spread = sdf_pkg::RST_SPREAD;

	sdf_result_t pending_results[$];
	int errors;
	int idle_pct;
	int n_loads, n_queries, n_bad, n_phases;
	int stall_cycles;

	initial forever #10 clk = ~clk;

	function automatic int eff_w();
		if (img_w == 0) return 1;
		if (img_w > MAP_W) return MAP_W;
		return int'(img_w);
	endfunction

	function automatic int eff_h();
		if (img_h == 0) return 1;
		if (img_h > MAP_H) return MAP_H;
		return int'(img_h);
	endfunction

	function automatic int eff_spread();
		return (spread < sdf_pkg::MIN_SPREAD) ? int'(sdf_pkg::MIN_SPREAD) : int'(spread);
	endfunction

	function automatic int reach();
		return (eff_spread() + 15) >> 4;
	endfunction

	// Floor square root, result fits in 13 bits
	function automatic int root_floor(int unsigned v);
		int unsigned r;
		int unsigned c;
		r = 0;
		for (int b = 12; b >= 0; b--) begin
			c = r | (32'd1 << b);
			if (c * c <= v) r = c;
		end
		return r;
	endfunction

	// Expected result of a query at (qx, qy)
	function automatic sdf_result_t distance_of(int qx, int qy);
		sdf_result_t r;
		int w, h, sp, d, x0, x1, y0, y1, best, dist_v, lim, sd, dx, dy;
		bit base;
		w  = eff_w();
		h  = eff_h();
		sp = eff_spread();
		r  = '0;
		if (qx >= w || qy >= h) begin
			r.bad = 1'b1;
			return r;
		end
		base = pixel_map[qy*MAP_W + qx];
		d    = (sp + 15) >> 4;
		x0   = (qx > d) ? qx - d : 0;
		y0   = (qy > d) ? qy - d : 0;
		x1   = (qx + d < w - 1) ? qx + d : w - 1;
		y1   = (qy + d < h - 1) ? qy + d : h - 1;
		best = d * d;
		for (int cy = y0; cy <= y1; cy++)
			for (int cx = x0; cx <= x1; cx++)
				if (pixel_map[cy*MAP_W + cx] != base) begin
					dx = cx - qx;
					dy = cy - qy;
					if (dx*dx + dy*dy < best) best = dx*dx + dy*dy;
				end
		dist_v = root_floor(best << 16);
		lim    = sp << 4;
		if (dist_v > lim) dist_v = lim;
		sd = base ? dist_v : -dist_v;
		r.alpha = 8'((255 * (lim + sd)) / (2 * lim));
		r.sdist = 14'(sd);
		r.is_in = base;
		return r;
	endfunction

	// Send one item; updates the predictor on acceptance
	task automatic send_item(logic act, int ix, int iy, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] a);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		action   <= act;
		px       <= 10'(ix);
		py       <= 10'(iy);
		red      <= r;
		green    <= g;
		blue     <= b;
		alpha_in <= a;
		do @(posedge clk); while (busy);
		if (act == sdf_pkg::ACT_LOAD) begin
			n_loads++;
			if (ix < eff_w() && iy < eff_h())
				pixel_map[iy*MAP_W + ix] = (|((r | g | b) & 8'h80)) && a[7];
		end else begin
			n_queries++;
			pending_results.insert(pending_results.size(), distance_of(ix, iy));
			if (ix >= eff_w() || iy >= eff_h()) n_bad++;
		end
	endtask

	// Load a pixel of the wanted class with random channels
	task automatic load_pixel(int ix, int iy, bit want_in);
		logic [7:0] c [4];
		foreach (c[i]) c[i] = 8'($urandom_range(255));
		if (want_in) begin
			c[$urandom_range(2)][7] = 1'b1;
			c[3][7] = 1'b1;
		end else if ($urandom_range(1)) begin
			c[3][7] = 1'b0;
		end else begin
			c[0][7] = 1'b0; c[1][7] = 1'b0; c[2][7] = 1'b0;
		end
		send_item(sdf_pkg::ACT_LOAD, ix, iy, c[0], c[1], c[2], c[3]);
	endtask

	// Fill a region: 0 random blobs, 1 all inside, 2 all outside
	task automatic load_region(int rx, int ry, int rw, int rh, int mode);
		int cx, cy, rad;
		cx  = rx + $urandom_range(rw - 1);
		cy  = ry + $urandom_range(rh - 1);
		rad = $urandom_range(1, 4);
		for (int j = ry; j < ry + rh; j++)
			for (int i = rx; i < rx + rw; i++)
				case (mode)
					0: load_pixel(i, j, ((i-cx)*(i-cx) + (j-cy)*(j-cy) <= rad*rad) ^
						($urandom_range(9) == 0));
					1: load_pixel(i, j, 1'b1);
					default: load_pixel(i, j, 1'b0);
				endcase
	endtask

	// Query a pixel whose clipped window lies wholly in the loaded region
	task automatic query_region(int rx, int ry, int rw, int rh);
		int d, lx, hx, ly, hy;
		d  = reach();
		lx = (rx == 0) ? 0 : rx + d;
		hx = (rx + rw == eff_w()) ? eff_w() - 1 : rx + rw - 1 - d;
		ly = (ry == 0) ? 0 : ry + d;
		hy = (ry + rh == eff_h()) ? eff_h() - 1 : ry + rh - 1 - d;
		send_item(sdf_pkg::ACT_QUERY, $urandom_range(hx, lx), $urandom_range(hy, ly),
			'0, '0, '0, '0);
	endtask

	// Wait until no result is owed and the engine is idle
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [10:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			sdf_pkg::REG_WIDTH:  img_w  = val;
			sdf_pkg::REG_HEIGHT: img_h  = val;
			sdf_pkg::REG_SPREAD: spread = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(int w, int h, int sp);
		settle();
		write_reg(sdf_pkg::REG_WIDTH, 11'(w));
		write_reg(sdf_pkg::REG_HEIGHT, 11'(h));
		write_reg(sdf_pkg::REG_SPREAD, 11'(sp));
		n_phases++;
	endtask

	// Reset values: far corner of the full image
	task automatic test_reset_values();
		load_region(1014, 1014, 10, 10, 0);
		send_item(sdf_pkg::ACT_QUERY, 1023, 1023, '0, '0, '0, '0);
		send_item(sdf_pkg::ACT_QUERY, 1018, 1018, '0, '0, '0, '0);
		repeat (6) query_region(1014, 1014, 10, 10);
	endtask

	// Out-of-range sizes, small spread, unused index, channel thresholds
	task automatic test_register_limits();
		logic [7:0] pat [7][4] = '{
			'{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255, 8'd255},
			'{8'd127, 8'd127, 8'd127, 8'd255}, '{8'd128, 8'd0, 8'd0, 8'd128},
			'{8'd0, 8'd128, 8'd0, 8'd128}, '{8'd0, 8'd0, 8'd128, 8'd128},
			'{8'd255, 8'd255, 8'd255, 8'd127}};
		settle();
		write_reg(sdf_pkg::REG_WIDTH, 11'd0);
		write_reg(sdf_pkg::REG_HEIGHT, 11'd2047);
		write_reg(sdf_pkg::REG_SPREAD, 11'd0);
		write_reg(REG_UNUSED, 11'h7ff);
		n_phases++;
		// whole column one class: nothing of the other class in reach
		load_region(0, 0, 1, 8, 1);
		send_item(sdf_pkg::ACT_QUERY, 0, 3, '0, '0, '0, '0);
		for (int i = 0; i < 7; i++)
			send_item(sdf_pkg::ACT_LOAD, 0, i, pat[i][0], pat[i][1], pat[i][2], pat[i][3]);
		for (int i = 0; i < 7; i++)
			send_item(sdf_pkg::ACT_QUERY, 0, i, '0, '0, '0, '0);
		send_item(sdf_pkg::ACT_LOAD, 1, 0, 8'hff, 8'hff, 8'hff, 8'hff);
		send_item(sdf_pkg::ACT_QUERY, 1, 0, '0, '0, '0, '0);
		send_item(sdf_pkg::ACT_QUERY, 1023, 1023, '0, '0, '0, '0);
	endtask

	// Widest spread on a small image, window clipped on every side
	task automatic test_wide_spread();
		configure(8, 6, 255);
		load_region(0, 0, 8, 6, 2);
		send_item(sdf_pkg::ACT_QUERY, 5, 5, '0, '0, '0, '0);
		load_region(0, 0, 8, 6, 0);
		send_item(sdf_pkg::ACT_QUERY, 0, 0, '0, '0, '0, '0);
		send_item(sdf_pkg::ACT_QUERY, 7, 5, '0, '0, '0, '0);
		send_item(sdf_pkg::ACT_QUERY, 8, 0, '0, '0, '0, '0);
		send_item(sdf_pkg::ACT_QUERY, 0, 6, '0, '0, '0, '0);
		repeat (6) query_region(0, 0, 8, 6);
	endtask

	// Random phases: random sizes, spread and region, then a mixed stream
	task automatic test_random(int phases);
		int w, h, sp, ew, eh, d, rw, rh, rx, ry, pick;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(5))
				0: begin w = 1024; h = $urandom_range(1, 16); end
				1: begin w = $urandom_range(1, 16); h = $urandom_range(1025, 2047); end
				2: begin w = 0; h = $urandom_range(1, 40); end
				default: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
			endcase
			sp = ($urandom_range(7) == 0) ? $urandom_range(0, 15) : $urandom_range(16, 40);
			if (w > 0 && w <= 12 && h <= 12 && $urandom_range(1)) sp = $urandom_range(200, 255);
			configure(w, h, sp);
			ew = eff_w();
			eh = eff_h();
			d  = reach();
			rw = (2*d + 1 + $urandom_range(3) < ew) ? 2*d + 1 + $urandom_range(3) : ew;
			rh = (2*d + 1 + $urandom_range(3) < eh) ? 2*d + 1 + $urandom_range(3) : eh;
			rx = $urandom_range(ew - rw);
			ry = $urandom_range(eh - rh);
			load_region(rx, ry, rw, rh, 0);
			for (int k = 0; k < 24; k++) begin
				pick = $urandom_range(99);
				if (pick < 55)
					query_region(rx, ry, rw, rh);
				else if (pick < 80)
					load_pixel(rx + $urandom_range(rw - 1), ry + $urandom_range(rh - 1),
						1'($urandom_range(1)));
				else if (pick < 90 && ew < MAP_W)
					load_pixel($urandom_range(1023, ew), $urandom_range(1023),
						1'($urandom_range(1)));
				else if (ew < MAP_W)
					send_item(sdf_pkg::ACT_QUERY, $urandom_range(1023, ew),
						$urandom_range(1023), '0, '0, '0, '0);
				else if (eh < MAP_H)
					send_item(sdf_pkg::ACT_QUERY, $urandom_range(1023),
						$urandom_range(1023, eh), '0, '0, '0, '0);
				else
					query_region(rx, ry, rw, rh);
			end
			// hold off until everything owed has come back
			if (p == 1) settle();
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		sdf_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: alpha %0d dist %0d in %0b bad %0b",
					$time, alpha_out, signed_distance, is_inside, bad_coordinate);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (alpha_out !== want.alpha) begin
					$display("%0t: alpha_out expected %0d actual %0d", $time, want.alpha,
						alpha_out);
					errors++;
				end
				if (signed_distance !== want.sdist) begin
					$display("%0t: signed_distance expected %0d actual %0d", $time,
						want.sdist, signed_distance);
					errors++;
				end
				if (is_inside !== want.is_in) begin
					$display("%0t: is_inside expected %0b actual %0b", $time, want.is_in,
						is_inside);
					errors++;
				end
				if (bad_coordinate !== want.bad) begin
					$display("%0t: bad_coordinate expected %0b actual %0b", $time, want.bad,
						bad_coordinate);
					errors++;
				end
			end
		end
	end

	// Watchdog: cycles with no item, result or register write
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("signed_distance_field_tb NOT OK");
			$finish;
		end
	end

	initial begin
		idle_pct = 37;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_register_limits();
		test_wide_spread();
		test_random(2);
		idle_pct = 87;
		test_random(1);
		idle_pct = 0;
		test_random(2);
		settle();
		repeat (40) @(posedge clk);
		$display("covered %0d phases: %0d loads, %0d queries (%0d outside the image)",
			n_phases, n_loads, n_queries, n_bad);
		$display("size and spread registers swept incl. zero, oversize and unused index");
		if (errors == 0 && pending_results.size() == 0)
			$display("signed_distance_field_tb OK");
		else
			$display("signed_distance_field_tb NOT OK");
		$finish;
	end

endmodule
